@@ hdl/mvfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mvfr_pkg: shared types and constants
// Widths, opcodes, register indexes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mvfr_pkg;

  // Capacities
  localparam int MAX_VERTICES  = 65536;
  localparam int MAX_TRIANGLES = 1048576;

  // Field widths
  localparam int VTX_W     = $clog2(MAX_VERTICES);
  localparam int TRI_W     = $clog2(MAX_TRIANGLES);
  localparam int VCNT_W    = VTX_W + 1;
  localparam int TCNT_W    = TRI_W + 1;
  localparam int TYPE_W    = 8;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int MAP_W     = VTX_W + 1;  // seen flag + new index

  // Input modes
  localparam logic [MODE_W-1:0] MODE_SET_TYPE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRIANGLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_HIGH = 1'b1;

  // Configuration reset values
  localparam logic signed [TYPE_W-1:0] TYPE_LOW_RST  = -8'sd128;
  localparam logic signed [TYPE_W-1:0] TYPE_HIGH_RST = 8'sd127;

  // Vertex counter saturates here
  localparam logic [VCNT_W-1:0] VCNT_SAT = '1;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_OK,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_CAP_C,
    ST_RN_A,
    ST_RN_B,
    ST_RN_C,
    ST_Q_RD,
    ST_Q_CAP,
    ST_FINISH
  } mvfr_state_t;

  // Which stored vertex index drives a memory address
  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_C,
    SEL_V
  } mvfr_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      load_in;
    logic      clr;
    logic      ok_wr;
    logic      rd;
    mvfr_sel_t rd_sel;
    logic      cap;
    mvfr_sel_t cap_sel;
    logic      keep;
    logic      renum;
    mvfr_sel_t rn_sel;
    logic      finish;
  } mvfr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_done;
    logic keep_ok;
    logic out_busy;
  } mvfr_status_t;

endpackage
`default_nettype wire

@@ hdl/mvfr_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mvfr_ram: generic single-port RAM
// One address per cycle, write or read, registered read data (old data on a
// write to the same address).
// ----------------------------------------------------------------------------
module mvfr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ hdl/mvfr_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mvfr_ctrl: sequencing controller
// Runs the post-reset clearing pass, then steps each accepted beat through
// its table accesses, renumber writes and result load.
// ----------------------------------------------------------------------------
module mvfr_ctrl import mvfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] mode,
  output logic              in_stall,
  input  mvfr_status_t      status,
  output mvfr_cmd_t         cmd
);

  mvfr_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (mode)
            MODE_SET_TYPE: state_next = ST_WR_OK;
            MODE_TRIANGLE: state_next = ST_RD_A;
            MODE_QUERY:    state_next = ST_Q_RD;
            default:       state_next = ST_FINISH;
          endcase
        end
      end
      ST_WR_OK: state_next = ST_FINISH;
      ST_RD_A:  state_next = ST_RD_B;
      ST_RD_B:  state_next = ST_RD_C;
      ST_RD_C:  state_next = ST_CAP_C;
      ST_CAP_C: state_next = ST_RN_A;
      ST_RN_A:  state_next = status.keep_ok ? ST_RN_B : ST_FINISH;
      ST_RN_B:  state_next = ST_RN_C;
      ST_RN_C:  state_next = ST_FINISH;
      ST_Q_RD:  state_next = ST_Q_CAP;
      ST_Q_CAP: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = SEL_A;
    cmd.cap_sel = SEL_A;
    cmd.rn_sel  = SEL_A;
    in_stall    = 1'b1;
    unique case (state)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_WR_OK: cmd.ok_wr = 1'b1;
      ST_RD_A: begin
        cmd.rd     = 1'b1;
        cmd.rd_sel = SEL_A;
      end
      ST_RD_B: begin
        cmd.rd      = 1'b1;
        cmd.rd_sel  = SEL_B;
        cmd.cap     = 1'b1;
        cmd.cap_sel = SEL_A;
      end
      ST_RD_C: begin
        cmd.rd      = 1'b1;
        cmd.rd_sel  = SEL_C;
        cmd.cap     = 1'b1;
        cmd.cap_sel = SEL_B;
      end
      ST_CAP_C: begin
        cmd.cap     = 1'b1;
        cmd.cap_sel = SEL_C;
      end
      ST_RN_A: begin
        cmd.keep   = status.keep_ok;
        cmd.renum  = status.keep_ok;
        cmd.rn_sel = SEL_A;
      end
      ST_RN_B: begin
        cmd.renum  = 1'b1;
        cmd.rn_sel = SEL_B;
      end
      ST_RN_C: begin
        cmd.renum  = 1'b1;
        cmd.rn_sel = SEL_C;
      end
      ST_Q_RD: begin
        cmd.rd     = 1'b1;
        cmd.rd_sel = SEL_V;
      end
      ST_Q_CAP: begin
        cmd.cap     = 1'b1;
        cmd.cap_sel = SEL_A;
      end
      ST_FINISH: cmd.finish = !status.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/mvfr_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mvfr_datapath: vertex tables, counters and result register
// Holds the acceptance map and the seen/new-index map in single-port RAMs,
// the type range registers, the dense counters and the output beat.
// ----------------------------------------------------------------------------
module mvfr_datapath import mvfr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  mvfr_cmd_t                cmd,
  output mvfr_status_t             status,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [TYPE_W-1:0]        cfg_data,
  // input payload
  input  logic [MODE_W-1:0]        mode,
  input  logic [VTX_W-1:0]         vertex_index,
  input  logic signed [TYPE_W-1:0] node_type,
  input  logic [VTX_W-1:0]         corner_a,
  input  logic [VTX_W-1:0]         corner_b,
  input  logic [VTX_W-1:0]         corner_c,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     tri_kept,
  output logic [VTX_W-1:0]         new_corner_a,
  output logic [VTX_W-1:0]         new_corner_b,
  output logic [VTX_W-1:0]         new_corner_c,
  output logic [TRI_W-1:0]         new_tri_index,
  output logic                     vertex_seen,
  output logic [VTX_W-1:0]         vertex_new_index,
  output logic [VCNT_W-1:0]        kept_vertex_total,
  output logic [TCNT_W-1:0]        kept_triangle_total
);

  // Type range
  logic signed [TYPE_W-1:0] type_low, type_high;

  // Registered input beat
  logic [MODE_W-1:0]        mode_r;
  logic [VTX_W-1:0]         vi_r, ca_r, cb_r, cc_r;
  logic signed [TYPE_W-1:0] nt_r;

  // Captured table reads per corner
  logic             ok_a, ok_b, ok_c;
  logic             seen_a, seen_b, seen_c;
  logic [VTX_W-1:0] idx_a, idx_b, idx_c;

  // Per-item results
  logic             kept;
  logic [VTX_W-1:0] new_a, new_b, new_c;
  logic [TRI_W-1:0] tri_idx;

  // Counters
  logic [VCNT_W-1:0] vtx_cnt;
  logic [TCNT_W-1:0] tri_cnt;
  logic [VTX_W-1:0]  clr_addr;

  // Memory ports
  logic             ok_we, ok_wdata, ok_rdata;
  logic [VTX_W-1:0] ok_addr;
  logic             map_we;
  logic [VTX_W-1:0] map_addr;
  logic [MAP_W-1:0] map_wdata, map_rdata;

  // Address selection and renumbering
  logic [VTX_W-1:0] rd_addr, rn_addr;
  logic             rn_fresh;
  logic [VTX_W-1:0] rn_val;
  logic             in_range;
  logic             is_query;

  function automatic logic [VTX_W-1:0] pick_addr(input mvfr_sel_t sel,
                                                 input logic [VTX_W-1:0] a,
                                                 input logic [VTX_W-1:0] b,
                                                 input logic [VTX_W-1:0] c,
                                                 input logic [VTX_W-1:0] v);
    logic [VTX_W-1:0] r;
    unique case (sel)
      SEL_A:   r = a;
      SEL_B:   r = b;
      SEL_C:   r = c;
      SEL_V:   r = v;
      default: r = v;
    endcase
    return r;
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      type_low  <= TYPE_LOW_RST;
      type_high <= TYPE_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TYPE_LOW:  type_low  <= cfg_data;
        CFG_TYPE_HIGH: type_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input beat register
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= mode;
      vi_r   <= vertex_index;
      nt_r   <= node_type;
      ca_r   <= corner_a;
      cb_r   <= corner_b;
      cc_r   <= corner_c;
    end
  end

  assign in_range = (nt_r >= type_low) && (nt_r <= type_high);
  assign rd_addr  = pick_addr(cmd.rd_sel, ca_r, cb_r, cc_r, vi_r);
  assign rn_addr  = pick_addr(cmd.rn_sel, ca_r, cb_r, cc_r, vi_r);

  // Renumber decision: repeated corners reuse the number given earlier
  always_comb begin
    rn_fresh = 1'b0;
    rn_val   = vtx_cnt[VTX_W-1:0];
    case (cmd.rn_sel)
      SEL_A: begin
        if (seen_a) rn_val = idx_a;
        else        rn_fresh = 1'b1;
      end
      SEL_B: begin
        if (cb_r == ca_r) rn_val = new_a;
        else if (seen_b)  rn_val = idx_b;
        else              rn_fresh = 1'b1;
      end
      SEL_C: begin
        if (cc_r == ca_r)      rn_val = new_a;
        else if (cc_r == cb_r) rn_val = new_b;
        else if (seen_c)       rn_val = idx_c;
        else                   rn_fresh = 1'b1;
      end
      default: ;
    endcase
  end

  // Acceptance map port
  assign ok_we    = cmd.clr | cmd.ok_wr;
  assign ok_addr  = cmd.clr ? clr_addr : (cmd.ok_wr ? vi_r : rd_addr);
  assign ok_wdata = cmd.clr ? 1'b0 : in_range;

  // Seen / new-index map port
  assign map_we    = cmd.clr | (cmd.renum & rn_fresh);
  assign map_addr  = cmd.clr ? clr_addr : (cmd.renum ? rn_addr : rd_addr);
  assign map_wdata = cmd.clr ? '0 : {1'b1, vtx_cnt[VTX_W-1:0]};

  mvfr_ram #(
    .WIDTH (1),
    .DEPTH (MAX_VERTICES)
  ) u_ok_ram (
    .clk   (clk),
    .we    (ok_we),
    .addr  (ok_addr),
    .wdata (ok_wdata),
    .rdata (ok_rdata)
  );

  mvfr_ram #(
    .WIDTH (MAP_W),
    .DEPTH (MAX_VERTICES)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .addr  (map_addr),
    .wdata (map_wdata),
    .rdata (map_rdata)
  );

  // Capture of registered reads
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      case (cmd.cap_sel)
        SEL_A: begin
          ok_a   <= ok_rdata;
          seen_a <= map_rdata[MAP_W-1];
          idx_a  <= map_rdata[VTX_W-1:0];
        end
        SEL_B: begin
          ok_b   <= ok_rdata;
          seen_b <= map_rdata[MAP_W-1];
          idx_b  <= map_rdata[VTX_W-1:0];
        end
        SEL_C: begin
          ok_c   <= ok_rdata;
          seen_c <= map_rdata[MAP_W-1];
          idx_c  <= map_rdata[VTX_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Per-item results; cleared when a beat is taken
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kept    <= 1'b0;
      new_a   <= '0;
      new_b   <= '0;
      new_c   <= '0;
      tri_idx <= '0;
    end else begin
      if (cmd.keep) begin
        kept    <= 1'b1;
        tri_idx <= tri_cnt[TRI_W-1:0];
      end
      if (cmd.renum) begin
        case (cmd.rn_sel)
          SEL_A:   new_a <= rn_val;
          SEL_B:   new_b <= rn_val;
          SEL_C:   new_c <= rn_val;
          default: ;
        endcase
      end
    end
  end

  // Dense counters and clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      vtx_cnt  <= '0;
      tri_cnt  <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.renum && rn_fresh && (vtx_cnt != VCNT_SAT)) begin
        vtx_cnt <= VCNT_W'(vtx_cnt + 1'b1);
      end
      if (cmd.keep) begin
        tri_cnt <= TCNT_W'(tri_cnt + 1'b1);
      end
      if (cmd.clr) begin
        clr_addr <= VTX_W'(clr_addr + 1'b1);
      end
    end
  end

  assign is_query = (mode_r == MODE_QUERY);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      tri_kept            <= kept;
      new_corner_a        <= new_a;
      new_corner_b        <= new_b;
      new_corner_c        <= new_c;
      new_tri_index       <= tri_idx;
      vertex_seen         <= is_query & seen_a;
      vertex_new_index    <= (is_query && seen_a) ? idx_a : '0;
      kept_vertex_total   <= vtx_cnt;
      kept_triangle_total <= tri_cnt;
    end
  end

  // Status
  assign status.clr_done = (clr_addr == '1);
  assign status.keep_ok  = ok_a & ok_b & ok_c & (tri_cnt < TCNT_W'(MAX_TRIANGLES));
  assign status.out_busy = out_valid & out_stall;

  // Checks
  a_vtx_bound: assert property (@(posedge clk) disable iff (rst)
    vtx_cnt <= VCNT_W'(MAX_VERTICES))
    else $error("vertex counter beyond capacity");

  a_tri_bound: assert property (@(posedge clk) disable iff (rst)
    tri_cnt <= TCNT_W'(MAX_TRIANGLES))
    else $error("triangle counter beyond capacity");

  a_renum_kept: assert property (@(posedge clk) disable iff (rst)
    cmd.renum |=> kept)
    else $error("vertex renumbered for a dropped triangle");

  a_clr_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.clr |-> !(cmd.ok_wr || cmd.renum || cmd.load_in || cmd.finish))
    else $error("table activity during clearing sweep");

endmodule
`default_nettype wire

@@ hdl/mesh_vertex_filter_and_renumber_top.sv @@
`default_nettype none
// Accept to result: a set-type beat writes the acceptance map; a triangle reads its
// corners in turn from the single-port vertex tables, then renumbers them in order
// if kept; a query reads one vertex; an unused mode loads the result at once. The
// next beat is taken the cycle after the result loads, even while that result is
// still stalled. Reset (rst, synchronous) starts a clearing pass over every entry;
// input stays stalled for it, configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// mesh_vertex_filter_and_renumber_top: vertex filter and dense renumbering
// Marks vertices acceptable by type range, keeps triangles with all corners
// acceptable and gives first-seen dense numbers to their vertices.
// ----------------------------------------------------------------------------
module mesh_vertex_filter_and_renumber_top import mvfr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [TYPE_W-1:0]        cfg_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [MODE_W-1:0]        mode,
  input  logic [VTX_W-1:0]         vertex_index,
  input  logic signed [TYPE_W-1:0] node_type,
  input  logic [VTX_W-1:0]         corner_a,
  input  logic [VTX_W-1:0]         corner_b,
  input  logic [VTX_W-1:0]         corner_c,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     tri_kept,
  output logic [VTX_W-1:0]         new_corner_a,
  output logic [VTX_W-1:0]         new_corner_b,
  output logic [VTX_W-1:0]         new_corner_c,
  output logic [TRI_W-1:0]         new_tri_index,
  output logic                     vertex_seen,
  output logic [VTX_W-1:0]         vertex_new_index,
  output logic [VCNT_W-1:0]        kept_vertex_total,
  output logic [TCNT_W-1:0]        kept_triangle_total
);

  mvfr_cmd_t    cmd;
  mvfr_status_t status;

  // Sequencer
  mvfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Tables, counters and result beat
  mvfr_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mode                (mode),
    .vertex_index        (vertex_index),
    .node_type           (node_type),
    .corner_a            (corner_a),
    .corner_b            (corner_b),
    .corner_c            (corner_c),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .tri_kept            (tri_kept),
    .new_corner_a        (new_corner_a),
    .new_corner_b        (new_corner_b),
    .new_corner_c        (new_corner_c),
    .new_tri_index       (new_tri_index),
    .vertex_seen         (vertex_seen),
    .vertex_new_index    (vertex_new_index),
    .kept_vertex_total   (kept_vertex_total),
    .kept_triangle_total (kept_triangle_total)
  );

endmodule
`default_nettype wire
